[rtl/core/mch_pkg.sv]
// Shared types and constants for the calibrated compass heading block.
`timescale 1ns / 1ps

package mch_pkg;

    typedef struct packed {
        logic signed [15:0] field_z;
        logic signed [15:0] field_y;
        logic signed [15:0] field_x;
    } mch_in_t;

    typedef struct packed {
        logic        [15:0] heading;
        logic signed [15:0] cal_z;
        logic signed [15:0] cal_y;
        logic signed [15:0] cal_x;
    } mch_out_t;

    localparam int TABLE_LEN = 24;
    localparam int CFG_W     = 48;
    localparam int IDX_W     = 3;

    localparam logic [IDX_W-1:0] REG_OFFSETS = 3'd0;
    localparam logic [IDX_W-1:0] REG_ROW_X   = 3'd1;
    localparam logic [IDX_W-1:0] REG_ROW_Y   = 3'd2;
    localparam logic [IDX_W-1:0] REG_ROW_Z   = 3'd3;
    localparam logic [IDX_W-1:0] REG_DECL    = 3'd4;

    localparam logic signed [34:0] QUARTER_Z = 35'sd2304000;
    localparam logic signed [17:0] HALF_TURN = 18'sd18000;
    localparam logic signed [17:0] FULL_TURN = 18'sd36000;

    // Arctangent of 2^-i in units of 1/25600 degree.
    function automatic logic signed [34:0] atan_entry(input int i);
        logic signed [34:0] r;
        begin
            case (i)
                0:  r = 35'sd1152000;
                1:  r = 35'sd680065;
                2:  r = 35'sd359328;
                3:  r = 35'sd182400;
                4:  r = 35'sd91554;
                5:  r = 35'sd45822;
                6:  r = 35'sd22916;
                7:  r = 35'sd11459;
                8:  r = 35'sd5730;
                9:  r = 35'sd2865;
                10: r = 35'sd1432;
                11: r = 35'sd716;
                12: r = 35'sd358;
                13: r = 35'sd179;
                14: r = 35'sd90;
                15: r = 35'sd45;
                16: r = 35'sd22;
                17: r = 35'sd11;
                18: r = 35'sd6;
                19: r = 35'sd3;
                20: r = 35'sd1;
                21: r = 35'sd1;
                default: r = 35'sd0;
            endcase
            return r;
        end
    endfunction

endpackage

[rtl/core/magnetometer_calibrated_heading.sv]
// Top level of the calibrated compass heading pipeline.
`timescale 1ns / 1ps

// Channel   Handshake            Payload
// input     start / busy         sample (mch_in_t)
// result    done (one cycle)     result (mch_out_t)
// config    cfg_we               cfg_index, cfg_data
//
// One beat enters per cycle; busy is held low. The registered stages are, in order:
// offset, nine products, sum, saturate, rotate, one CORDIC stage per iteration,
// then heading wrap.
// Reset clears the valid bits and loads identity calibration.
// The receiver cannot stall, so the pipeline never stops.

module magnetometer_calibrated_heading
    import mch_pkg::*;
#(
    parameter int ANGLE_ITERATIONS = 16
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  mch_in_t              sample,
    output logic                 done,
    output mch_out_t             result,
    input  logic                 cfg_we,
    input  logic [IDX_W-1:0]     cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int NIT = (ANGLE_ITERATIONS < TABLE_LEN) ? ANGLE_ITERATIONS : TABLE_LEN;

    logic [CFG_W-1:0] offsets_reg, row_x_reg, row_y_reg, row_z_reg;
    logic [15:0]      decl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offsets_reg <= '0;
            row_x_reg   <= 48'd16384;
            row_y_reg   <= 48'd1073741824;
            row_z_reg   <= 48'd70368744177664;
            decl_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_OFFSETS: offsets_reg <= cfg_data;
                REG_ROW_X:   row_x_reg   <= cfg_data;
                REG_ROW_Y:   row_y_reg   <= cfg_data;
                REG_ROW_Z:   row_z_reg   <= cfg_data;
                REG_DECL:    decl_reg    <= cfg_data[15:0];
                default:     ;
            endcase
        end
    end

    assign busy = 1'b0;

    // Stage 1: offset subtraction.
    logic              v1_reg;
    logic signed [16:0] d_reg [3];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v1_reg <= 1'b0;
        else        v1_reg <= start;
    end
    always_ff @(posedge clk)
    begin
        d_reg[0] <= 17'(sample.field_x) - 17'($signed(offsets_reg[15:0]));
        d_reg[1] <= 17'(sample.field_y) - 17'($signed(offsets_reg[31:16]));
        d_reg[2] <= 17'(sample.field_z) - 17'($signed(offsets_reg[47:32]));
    end

    // Stage 2: nine products.
    logic               v2_reg;
    logic signed [32:0] p_reg [3][3];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v2_reg <= 1'b0;
        else        v2_reg <= v1_reg;
    end
    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 3; c++)
        begin
            p_reg[0][c] <= 33'($signed(row_x_reg[16*c +: 16]) * d_reg[c]);
            p_reg[1][c] <= 33'($signed(row_y_reg[16*c +: 16]) * d_reg[c]);
            p_reg[2][c] <= 33'($signed(row_z_reg[16*c +: 16]) * d_reg[c]);
        end
    end

    // Stage 3: sums.
    logic               v3_reg;
    logic signed [34:0] s_reg [3];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v3_reg <= 1'b0;
        else        v3_reg <= v2_reg;
    end
    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
            s_reg[r] <= 35'(p_reg[r][0]) + 35'(p_reg[r][1]) + 35'(p_reg[r][2]);
    end

    // Stage 4: shift and saturate.
    logic               v4_reg;
    logic signed [15:0] cal_reg [3];
    logic signed [20:0] sh [3];
    always_comb
    begin
        for (int r = 0; r < 3; r++)
            sh[r] = 21'(s_reg[r] >>> 14);
    end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v4_reg <= 1'b0;
        else        v4_reg <= v3_reg;
    end
    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
        begin
            if (sh[r] > 21'sd32767)       cal_reg[r] <= 16'sh7fff;
            else if (sh[r] < -21'sd32768) cal_reg[r] <= 16'sh8000;
            else                          cal_reg[r] <= sh[r][15:0];
        end
    end

    // Stage 5: quadrant turn. h is horizontal (cal_y), v vertical (cal_x).
    localparam int CW = 36;
    logic signed [CW-1:0] h0, v0;
    logic signed [34:0]   z0;
    assign h0 = CW'(cal_reg[1]) <<< 16;
    assign v0 = CW'(cal_reg[0]) <<< 16;

    logic                 cv_reg [NIT+1];
    logic                 zero_reg [NIT+1];
    logic signed [CW-1:0] ch_reg [NIT+1];
    logic signed [CW-1:0] cvv_reg [NIT+1];
    logic signed [34:0]   cz_reg [NIT+1];
    logic signed [15:0]   cx_reg [NIT+1], cy_reg [NIT+1], czz_reg [NIT+1];

    always_comb
    begin
        z0 = '0;
        if (h0 < 0)
            z0 = (v0 >= 0) ? QUARTER_Z : -QUARTER_Z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) cv_reg[0] <= 1'b0;
        else        cv_reg[0] <= v4_reg;
    end
    always_ff @(posedge clk)
    begin
        zero_reg[0] <= (cal_reg[0] == 16'sd0) && (cal_reg[1] == 16'sd0);
        cx_reg[0]   <= cal_reg[0];
        cy_reg[0]   <= cal_reg[1];
        czz_reg[0]  <= cal_reg[2];
        cz_reg[0]   <= z0;
        if (h0 < 0)
        begin
            if (v0 >= 0)
            begin
                ch_reg[0]  <= v0;
                cvv_reg[0] <= -h0;
            end
            else
            begin
                ch_reg[0]  <= -v0;
                cvv_reg[0] <= h0;
            end
        end
        else
        begin
            ch_reg[0]  <= h0;
            cvv_reg[0] <= v0;
        end
    end

    // CORDIC stages, one micro-rotation each.
    for (genvar i = 0; i < NIT; i++)
    begin : g_cordic
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) cv_reg[i+1] <= 1'b0;
            else        cv_reg[i+1] <= cv_reg[i];
        end
        always_ff @(posedge clk)
        begin
            zero_reg[i+1] <= zero_reg[i];
            cx_reg[i+1]   <= cx_reg[i];
            cy_reg[i+1]   <= cy_reg[i];
            czz_reg[i+1]  <= czz_reg[i];
            if (cvv_reg[i] >= 0)
            begin
                ch_reg[i+1]  <= ch_reg[i] + (cvv_reg[i] >>> i);
                cvv_reg[i+1] <= cvv_reg[i] - (ch_reg[i] >>> i);
                cz_reg[i+1]  <= cz_reg[i] + atan_entry(i);
            end
            else
            begin
                ch_reg[i+1]  <= ch_reg[i] - (cvv_reg[i] >>> i);
                cvv_reg[i+1] <= cvv_reg[i] + (ch_reg[i] >>> i);
                cz_reg[i+1]  <= cz_reg[i] - atan_entry(i);
            end
        end
    end

    // Final stage: round, subtract a half turn, add declination, wrap. Angle lies in -18000..18000.
    logic signed [34:0] zr;
    logic signed [17:0] ang, hsum, hw;
    always_comb
    begin
        zr   = (cz_reg[NIT] + 35'sd128) >>> 8;
        ang  = zero_reg[NIT] ? 18'sd0 : zr[17:0];
        hsum = ang - HALF_TURN + 18'($signed(decl_reg));
        // hsum spans about -68768..32767, so at most two corrections are due.
        if (hsum < -FULL_TURN)     hw = hsum + FULL_TURN + FULL_TURN;
        else if (hsum < 0)         hw = hsum + FULL_TURN;
        else if (hsum >= FULL_TURN) hw = hsum - FULL_TURN;
        else                       hw = hsum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) done <= 1'b0;
        else        done <= cv_reg[NIT];
    end
    always_ff @(posedge clk)
    begin
        result.cal_x   <= cx_reg[NIT];
        result.cal_y   <= cy_reg[NIT];
        result.cal_z   <= czz_reg[NIT];
        result.heading <= hw[15:0];
    end

`ifndef SYNTHESIS
    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.heading < 16'd36000))
        else $error("heading out of range");
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg |-> ##(NIT + 2) done)
        else $error("beat lost in pipeline");
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");
`endif

endmodule

[tb/testbench.sv]
// Self-checking testbench for the calibrated compass heading pipeline.
`timescale 1ns / 1ps

module testbench;
    import mch_pkg::*;

    localparam int ITERS     = 16;
    localparam int LATENCY   = ITERS + 6;
    localparam int N_RANDOM  = 1500;
    localparam int CYCLE_CAP = 400000;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    mch_in_t          sample;
    logic             done;
    mch_out_t         result;
    logic             cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    magnetometer_calibrated_heading #(.ANGLE_ITERATIONS(ITERS)) u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .sample(sample),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Calibration copy kept by the predictor.
    logic [47:0] cal_offsets;
    logic [47:0] cal_rows [3];
    logic [15:0] cal_decl;

    mch_out_t pending_results [$];
    int       mismatches;
    int       cycles;

    // Directed rows: expected heading typed in where obvious (-1 means predict).
    typedef struct {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        int          want_heading;
    } stim_row_t;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_CAP)
            begin
                $display("testbench failed");
                $finish;
            end
        end
    end

    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint sat_to16(longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    function automatic longint atan_step(int i);
        longint steps [24] = '{1152000, 680065, 359328, 182400, 91554, 45822,
                               22916, 11459, 5730, 2865, 1432, 716, 358, 179,
                               90, 45, 22, 11, 6, 3, 1, 1, 0, 0};
        return steps[i];
    endfunction

    // Vectoring CORDIC: atan2(vert, horiz) in hundredths of a degree.
    function automatic longint bearing_of(longint vert, longint horiz);
        longint h;
        longint v;
        longint z;
        longint t;
        longint dh;
        longint dv;
        h = horiz * 65536;
        v = vert * 65536;
        z = 0;
        if (vert == 0 && horiz == 0)
            return 0;
        if (h < 0)
        begin
            if (v >= 0)
            begin
                t = h; h = v; v = -t; z = 2304000;
            end
            else
            begin
                t = h; h = -v; v = t; z = -2304000;
            end
        end
        for (int i = 0; i < ITERS && i < 24; i++)
        begin
            dh = floor_shr(v, i);
            dv = floor_shr(h, i);
            if (v >= 0)
            begin
                h += dh; v -= dv; z += atan_step(i);
            end
            else
            begin
                h -= dh; v += dv; z -= atan_step(i);
            end
        end
        return floor_shr(z + 128, 8);
    endfunction

    function automatic mch_out_t calibrate_heading(mch_in_t s);
        longint   diff [3];
        longint   axis [3];
        longint   acc;
        longint   hd;
        mch_out_t r;
        diff[0] = longint'(s.field_x) - longint'($signed(cal_offsets[15:0]));
        diff[1] = longint'(s.field_y) - longint'($signed(cal_offsets[31:16]));
        diff[2] = longint'(s.field_z) - longint'($signed(cal_offsets[47:32]));
        for (int row = 0; row < 3; row++)
        begin
            acc = 0;
            for (int col = 0; col < 3; col++)
                acc += longint'($signed(cal_rows[row][16*col +: 16])) * diff[col];
            axis[row] = sat_to16(floor_shr(acc, 14));
        end
        hd = bearing_of(axis[0], axis[1]) - 18000 + longint'($signed(cal_decl));
        hd = hd % 36000;
        if (hd < 0)
            hd += 36000;
        r.cal_x   = axis[0][15:0];
        r.cal_y   = axis[1][15:0];
        r.cal_z   = axis[2][15:0];
        r.heading = hd[15:0];
        return r;
    endfunction

    // Random idle on the sending side, except in the quiet stretch.
    function automatic bit sender_idles(int n);
        if (n >= 600 && n < 900)
            return 1'b0;
        return $urandom_range(99) < 30;
    endfunction

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_OFFSETS: cal_offsets = value;
            REG_ROW_X:   cal_rows[0] = value;
            REG_ROW_Y:   cal_rows[1] = value;
            REG_ROW_Z:   cal_rows[2] = value;
            REG_DECL:    cal_decl = value[15:0];
            default:     ;
        endcase
        @(posedge clk);
    endtask

    // Leaves start high so that beats can follow back to back.
    task automatic send_sample(mch_in_t s);
        start  <= 1'b1;
        sample <= s;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(calibrate_heading(s));
    endtask

    // Waits for every beat to drain, then for the pipeline depth.
    task automatic drain;
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    function automatic logic [47:0] rand48();
        return 48'({$urandom(), $urandom()});
    endfunction

    // Coefficients mostly near unity, with occasional extremes.
    function automatic logic [47:0] rand_row(int diag);
        logic [47:0] r;
        for (int c = 0; c < 3; c++)
        begin
            if ($urandom_range(9) == 0)
                r[16*c +: 16] = 16'($urandom());
            else if (c == diag)
                r[16*c +: 16] = 16'(16384 + $signed($urandom_range(4000)) - 2000);
            else
                r[16*c +: 16] = 16'($signed($urandom_range(4000)) - 2000);
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        mch_out_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: %h", result);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.cal_x !== want.cal_x || result.cal_y !== want.cal_y ||
                    result.cal_z !== want.cal_z || result.heading !== want.heading)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: want x=%0d y=%0d z=%0d hd=%0d, ",
                                  "got x=%0d y=%0d z=%0d hd=%0d"},
                                 want.cal_x, want.cal_y, want.cal_z, want.heading,
                                 result.cal_x, result.cal_y, result.cal_z,
                                 result.heading);
                end
            end
        end
    end

    initial
    begin
        stim_row_t table_rows [$];
        stim_row_t row;
        mch_in_t   s;
        mch_out_t  got;
        int        sent;

        mismatches  = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        sample      = '0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        cal_offsets = '0;
        cal_rows[0] = 48'd16384;
        cal_rows[1] = 48'd16384 << 16;
        cal_rows[2] = 48'd16384 << 32;
        cal_decl    = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset calibration: identity, no offset, no declination.
        // Zero vector gives angle 0, so heading is 180 degrees.
        table_rows = '{
            '{16'd0,      16'd0,      16'd0,      18000},
            '{16'd0,      16'd100,    16'd0,      18000},
            '{16'd100,    16'd0,      16'd5,      27000},
            '{16'hFF9C,   16'd0,      16'd0,      9000},
            '{16'd0,      16'hFF9C,   16'd0,      -1},
            '{16'h7FFF,   16'h7FFF,   16'h7FFF,   -1},
            '{16'h8000,   16'h8000,   16'h8000,   -1},
            '{16'h7FFF,   16'h8000,   16'h5555,   -1},
            '{16'h8000,   16'h7FFF,   16'hAAAA,   -1},
            '{16'd1,      16'hFFFF,   16'd0,      -1},
            '{16'hFFFF,   16'hFFFF,   16'd0,      -1}
        };
        foreach (table_rows[k])
        begin
            row = table_rows[k];
            s = '{field_z: row.z, field_y: row.y, field_x: row.x};
            got = calibrate_heading(s);
            if (row.want_heading >= 0 && got.heading != 16'(row.want_heading))
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("directed row %0d: want heading %0d, predicted %0d",
                             k, row.want_heading, got.heading);
            end
            send_sample(s);
        end
        drain();

        // Saturating matrix, extreme offsets and declinations.
        write_reg(REG_OFFSETS, {16'h8000, 16'h7FFF, 16'h8000});
        write_reg(REG_ROW_X, {16'h7FFF, 16'h7FFF, 16'h7FFF});
        write_reg(REG_ROW_Y, {16'h8000, 16'h8000, 16'h8000});
        write_reg(REG_ROW_Z, 48'hFFFF_FFFF_FFFF);
        write_reg(REG_DECL, 16'sd18000);
        foreach (table_rows[k])
            send_sample('{field_z: table_rows[k].z, field_y: table_rows[k].y,
                          field_x: table_rows[k].x});
        drain();
        write_reg(REG_DECL, -16'sd18000);
        write_reg(REG_OFFSETS, '0);
        write_reg(REG_ROW_X, '0);
        write_reg(REG_ROW_Y, '0);
        send_sample('{field_z: 16'd5, field_y: 16'd9, field_x: 16'd3});
        drain();
        // Out-of-range declination and an unused register index.
        write_reg(REG_DECL, 16'h8000);
        write_reg(3'd7, rand48());
        write_reg(REG_ROW_X, 48'd16384);
        write_reg(REG_ROW_Y, 48'd16384 << 16);
        send_sample('{field_z: 16'd0, field_y: 16'd300, field_x: 16'hFED4});
        drain();

        sent = 0;
        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase == 5)
            begin
                write_reg(REG_OFFSETS, '0);
                write_reg(REG_ROW_X, 48'd16384);
                write_reg(REG_ROW_Y, 48'd16384 << 16);
                write_reg(REG_ROW_Z, 48'd16384 << 32);
                write_reg(REG_DECL, 16'h7FFF);
            end
            else
            begin
                write_reg(REG_OFFSETS, phase == 4 ? rand48() :
                          {16'($signed($urandom_range(1000)) - 500),
                           16'($signed($urandom_range(1000)) - 500),
                           16'($signed($urandom_range(1000)) - 500)});
                write_reg(REG_ROW_X, rand_row(0));
                write_reg(REG_ROW_Y, rand_row(1));
                write_reg(REG_ROW_Z, rand_row(2));
                write_reg(REG_DECL, 16'($signed($urandom_range(36000)) - 18000));
            end
            for (int n = 0; n < N_RANDOM / 6; n++)
            begin
                while (sender_idles(sent))
                begin
                    start <= 1'b0;
                    @(posedge clk);
                end
                if ($urandom_range(3) == 0)
                    s = mch_in_t'(48'({$urandom(), $urandom()}));
                else
                    s = '{field_z: 16'($signed($urandom_range(1200)) - 600),
                          field_y: 16'($signed($urandom_range(1200)) - 600),
                          field_x: 16'($signed($urandom_range(1200)) - 600)};
                send_sample(s);
                sent++;
            end
            drain();
        end

        if (mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

[sim.f]
rtl/core/mch_pkg.sv
rtl/core/magnetometer_calibrated_heading.sv
tb/testbench.sv
